### rtl/core/pot_channel_selector_hysteresis_unit_macros.svh
// Assertion macros shared by the checker of the channel selector.
// No dependencies; the macros expect signals named clk and rst_n in scope.
`ifndef POT_CHANNEL_SELECTOR_HYSTERESIS_UNIT_MACROS_SVH
`define POT_CHANNEL_SELECTOR_HYSTERESIS_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCSH_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcsh same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PCSH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcsh next-cycle check failed");

`endif

### rtl/core/pcsh_pkg.sv
// Package of the knob channel selector: payload structs, codes, sizes.
// No dependencies; used by the top level and its checker.
package pcsh_pkg;

    localparam int CHANNELS_PER_BAND = 128;
    localparam int SAMPLE_BITS       = 12;
    localparam int SMOOTH_SHIFT_DEF  = 3;
    localparam int NUM_BANDS         = 2;
    localparam int CH_IDX_W          = $clog2(CHANNELS_PER_BAND);
    localparam int TABLE_DEPTH       = NUM_BANDS * CHANNELS_PER_BAND;
    localparam int TABLE_ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W             = 8;
    localparam int CFG_IDX_W         = 2;

    localparam logic [2:0] MODE_SAMPLE  = 3'd0;
    localparam logic [2:0] MODE_BAND    = 3'd1;
    localparam logic [2:0] MODE_WRITE   = 3'd2;
    localparam logic [2:0] MODE_ENABLE  = 3'd3;
    localparam logic [2:0] MODE_SUSPEND = 3'd4;

    localparam logic [1:0] EV_CH_DETUNE   = 2'd0;
    localparam logic [1:0] EV_CH_ENTUNE   = 2'd1;
    localparam logic [1:0] EV_BAND_DETUNE = 2'd2;
    localparam logic [1:0] EV_BAND_ENTUNE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BAND0_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND1_COUNT = 2'd1;

    typedef struct packed {
        logic [2:0]             mode;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   band_select;
        logic [CH_IDX_W-1:0]    entry_index;
        logic [SAMPLE_BITS-1:0] window_low;
        logic [SAMPLE_BITS-1:0] window_high;
        logic                   enable_bit;
        logic                   suspend_bit;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          event_kind;
        logic                event_band;
        logic [CH_IDX_W-1:0] event_channel;
        logic                last_event;
    } out_item_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] low;
        logic [SAMPLE_BITS-1:0] high;
        logic                   en;
    } win_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EN_WR,
        ST_SUS_CH,
        ST_SUS_BAND,
        ST_RES_BAND,
        ST_TUNE_RD,
        ST_TUNE_CHK,
        ST_T_CH,
        ST_T_BD,
        ST_T_BE,
        ST_SCAN_INIT,
        ST_SCAN,
        ST_T_EN,
        ST_FIN
    } state_t;

endpackage

### rtl/core/pot_channel_selector_hysteresis_unit.sv
// Knob channel selector with hysteresis: smoothing, window table, tune events.
// Depends on pcsh_pkg for payload structs, codes and the state type.
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+-------------------------------------
//  in      | in_valid / in_ready   | in_data  (in_item_t)
//  out     | out_valid / out_ready | out_data (out_item_t), one per event
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (entry counts)
//
// A window write or an unused mode returns to idle without a tuning pass. A retune scans the
// window table one entry at a time, up to the band's entry count (128 at most), since the
// table has a single read port.
// Output stalls hold the block only when a second event is ready to leave.
// Reset clears all control state; table entries are undefined until written.
module pot_channel_selector_hysteresis_unit
    import pcsh_pkg::*;
#(
    parameter int SMOOTH_SHIFT = SMOOTH_SHIFT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data
);

    localparam logic [CNT_W-1:0] CH_LIMIT = CNT_W'(CHANNELS_PER_BAND);

    state_t                 state_reg, state_next;
    in_item_t               item_reg, item_next;
    logic [SAMPLE_BITS-1:0] level_reg, level_next;
    logic                   level_vld_reg, level_vld_next;
    logic                   active_band_reg, active_band_next;
    logic                   req_band_reg, req_band_next;
    logic                   tuned_vld_reg, tuned_vld_next;
    logic [CH_IDX_W-1:0]    tuned_idx_reg, tuned_idx_next;
    logic                   susp_reg, susp_next;
    logic [CNT_W-1:0]       cnt0_reg, cnt0_next;
    logic [CNT_W-1:0]       cnt1_reg, cnt1_next;
    logic [CNT_W-1:0]       scan_idx_reg, scan_idx_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [CH_IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic                   pend_vld_reg, pend_vld_next;
    out_item_t              pend_reg, pend_next;
    logic                   out_vld_reg, out_vld_next;
    out_item_t              out_reg, out_next;

    win_t                    win_mem [0:TABLE_DEPTH-1];
    win_t                    rd_data_reg;
    logic [TABLE_ADDR_W-1:0] mem_rd_addr;
    logic                    mem_we;
    logic [TABLE_ADDR_W-1:0] mem_wr_addr;
    win_t                    mem_wr_data;

    logic                    emit_req;
    out_item_t               emit_item;
    logic                    out_free;
    logic                    can_emit;
    logic [CNT_W-1:0]        cnt_sel;
    logic [CNT_W-1:0]        cnt_lim;
    logic                    rd_hit;

    function automatic logic win_hit(input win_t w, input logic [SAMPLE_BITS-1:0] lvl,
                                     input logic lvl_vld);
        win_hit = lvl_vld && w.en && (lvl >= w.low) && (lvl < w.high);
    endfunction

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    assign out_free = !out_vld_reg || out_ready;
    assign can_emit = !pend_vld_reg || out_free;
    assign cnt_sel  = active_band_reg ? cnt1_reg : cnt0_reg;
    assign cnt_lim  = (cnt_sel > CH_LIMIT) ? CH_LIMIT : cnt_sel;
    assign rd_hit   = win_hit(rd_data_reg, level_reg, level_vld_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            win_mem[mem_wr_addr] <= mem_wr_data;
        end
        rd_data_reg <= win_mem[mem_rd_addr];
    end

    always_comb
    begin
        state_next       = state_reg;
        item_next        = item_reg;
        level_next       = level_reg;
        level_vld_next   = level_vld_reg;
        active_band_next = active_band_reg;
        req_band_next    = req_band_reg;
        tuned_vld_next   = tuned_vld_reg;
        tuned_idx_next   = tuned_idx_reg;
        susp_next        = susp_reg;
        cnt0_next        = cnt0_reg;
        cnt1_next        = cnt1_reg;
        scan_idx_next    = scan_idx_reg;
        chk_vld_next     = chk_vld_reg;
        chk_idx_next     = chk_idx_reg;
        pend_vld_next    = pend_vld_reg;
        pend_next        = pend_reg;
        out_vld_next     = out_vld_reg;
        out_next         = out_reg;

        mem_rd_addr = {active_band_reg, tuned_idx_reg};
        mem_we      = 1'b0;
        mem_wr_addr = {item_reg.band_select, item_reg.entry_index};
        mem_wr_data = '{low: item_reg.window_low, high: item_reg.window_high,
                        en: item_reg.enable_bit};
        emit_req    = 1'b0;
        emit_item   = '{event_kind: EV_CH_DETUNE, event_band: active_band_reg,
                        event_channel: tuned_idx_reg, last_event: 1'b0};

        if (out_vld_reg && out_ready)
        begin
            out_vld_next = 1'b0;
        end

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BAND0_COUNT: cnt0_next = cfg_data;
                CFG_BAND1_COUNT: cnt1_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (item_reg.mode)
                    MODE_SAMPLE:
                    begin
                        level_vld_next = 1'b1;
                        if (!level_vld_reg)
                        begin
                            level_next = item_reg.sample;
                        end
                        else
                        begin
                            level_next = level_reg - (level_reg >> SMOOTH_SHIFT)
                                         + (item_reg.sample >> SMOOTH_SHIFT);
                        end
                        state_next = susp_reg ? ST_FIN : ST_TUNE_RD;
                    end
                    MODE_BAND:
                    begin
                        req_band_next = item_reg.band_select;
                        state_next    = susp_reg ? ST_FIN : ST_TUNE_RD;
                    end
                    MODE_WRITE:
                    begin
                        mem_we     = 1'b1;
                        state_next = ST_IDLE;
                    end
                    MODE_ENABLE:
                    begin
                        mem_rd_addr = {item_reg.band_select, item_reg.entry_index};
                        state_next  = ST_EN_WR;
                    end
                    MODE_SUSPEND:
                    begin
                        if (item_reg.suspend_bit != susp_reg)
                        begin
                            state_next = item_reg.suspend_bit ? ST_SUS_CH : ST_RES_BAND;
                        end
                        else
                        begin
                            state_next = susp_reg ? ST_FIN : ST_TUNE_RD;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_EN_WR:
            begin
                mem_we      = 1'b1;
                mem_wr_data = '{low: rd_data_reg.low, high: rd_data_reg.high,
                                en: item_reg.enable_bit};
                state_next  = susp_reg ? ST_FIN : ST_TUNE_RD;
            end
            ST_SUS_CH:
            begin
                if (tuned_vld_reg)
                begin
                    emit_req = 1'b1;
                    if (can_emit)
                    begin
                        tuned_vld_next = 1'b0;
                        tuned_idx_next = '0;
                        state_next     = ST_SUS_BAND;
                    end
                end
                else
                begin
                    tuned_idx_next = '0;
                    state_next     = ST_SUS_BAND;
                end
            end
            ST_SUS_BAND:
            begin
                emit_req  = 1'b1;
                emit_item = '{event_kind: EV_BAND_DETUNE, event_band: active_band_reg,
                              event_channel: '0, last_event: 1'b0};
                if (can_emit)
                begin
                    susp_next  = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_RES_BAND:
            begin
                emit_req  = 1'b1;
                emit_item = '{event_kind: EV_BAND_ENTUNE, event_band: active_band_reg,
                              event_channel: '0, last_event: 1'b0};
                if (can_emit)
                begin
                    susp_next  = 1'b0;
                    state_next = ST_TUNE_RD;
                end
            end
            ST_TUNE_RD:
            begin
                state_next = ST_TUNE_CHK;
            end
            ST_TUNE_CHK:
            begin
                if ((req_band_reg == active_band_reg) && tuned_vld_reg && rd_hit)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_T_CH;
                end
            end
            ST_T_CH:
            begin
                if (tuned_vld_reg)
                begin
                    emit_req = 1'b1;
                end
                if (!tuned_vld_reg || can_emit)
                begin
                    state_next = (req_band_reg != active_band_reg) ? ST_T_BD : ST_SCAN_INIT;
                end
            end
            ST_T_BD:
            begin
                emit_req  = 1'b1;
                emit_item = '{event_kind: EV_BAND_DETUNE, event_band: active_band_reg,
                              event_channel: '0, last_event: 1'b0};
                if (can_emit)
                begin
                    state_next = ST_T_BE;
                end
            end
            ST_T_BE:
            begin
                emit_req  = 1'b1;
                emit_item = '{event_kind: EV_BAND_ENTUNE, event_band: req_band_reg,
                              event_channel: '0, last_event: 1'b0};
                if (can_emit)
                begin
                    active_band_next = req_band_reg;
                    state_next       = ST_SCAN_INIT;
                end
            end
            ST_SCAN_INIT:
            begin
                tuned_vld_next = 1'b0;
                tuned_idx_next = '0;
                scan_idx_next  = '0;
                chk_vld_next   = 1'b0;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (chk_vld_reg && rd_hit)
                begin
                    tuned_vld_next = 1'b1;
                    tuned_idx_next = chk_idx_reg;
                    chk_vld_next   = 1'b0;
                    state_next     = ST_T_EN;
                end
                else if (scan_idx_reg < cnt_lim)
                begin
                    mem_rd_addr   = {active_band_reg, scan_idx_reg[CH_IDX_W-1:0]};
                    chk_vld_next  = 1'b1;
                    chk_idx_next  = scan_idx_reg[CH_IDX_W-1:0];
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                else
                begin
                    chk_vld_next = 1'b0;
                    if (!chk_vld_reg)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_T_EN:
            begin
                emit_req  = 1'b1;
                emit_item = '{event_kind: EV_CH_ENTUNE, event_band: active_band_reg,
                              event_channel: tuned_idx_reg, last_event: 1'b0};
                if (can_emit)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!pend_vld_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next            = pend_reg;
                    out_next.last_event = 1'b1;
                    out_vld_next        = 1'b1;
                    pend_vld_next       = 1'b0;
                    state_next          = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // An event waits in the pending slot until the next one shows it is not the last.
        if (emit_req && can_emit)
        begin
            if (pend_vld_reg)
            begin
                out_next     = pend_reg;
                out_vld_next = 1'b1;
            end
            pend_next     = emit_item;
            pend_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            level_reg       <= '0;
            level_vld_reg   <= 1'b0;
            active_band_reg <= 1'b0;
            req_band_reg    <= 1'b0;
            tuned_vld_reg   <= 1'b0;
            tuned_idx_reg   <= '0;
            susp_reg        <= 1'b0;
            cnt0_reg        <= '0;
            cnt1_reg        <= '0;
            scan_idx_reg    <= '0;
            chk_vld_reg     <= 1'b0;
            chk_idx_reg     <= '0;
            pend_vld_reg    <= 1'b0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            level_reg       <= level_next;
            level_vld_reg   <= level_vld_next;
            active_band_reg <= active_band_next;
            req_band_reg    <= req_band_next;
            tuned_vld_reg   <= tuned_vld_next;
            tuned_idx_reg   <= tuned_idx_next;
            susp_reg        <= susp_next;
            cnt0_reg        <= cnt0_next;
            cnt1_reg        <= cnt1_next;
            scan_idx_reg    <= scan_idx_next;
            chk_vld_reg     <= chk_vld_next;
            chk_idx_reg     <= chk_idx_next;
            pend_vld_reg    <= pend_vld_next;
            out_vld_reg     <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

endmodule

### rtl/core/pcsh_checker.sv
// Port-level checker of the knob channel selector, bound to the top level.
// Depends on pcsh_pkg and the assertion macro header.
`include "pot_channel_selector_hysteresis_unit_macros.svh"

module pcsh_checker
    import pcsh_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // A stalled result keeps its place and its payload.
    `PCSH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

    // Band events never name a channel.
    `PCSH_ASSERT_SAME(a_band_no_channel, out_valid && out_data.event_kind[1], out_data.event_channel == '0)

    // A channel entune always closes the events of its item.
    `PCSH_ASSERT_SAME(a_entune_last, out_valid && (out_data.event_kind == EV_CH_ENTUNE), out_data.last_event)

    // After an input transfer the block is busy in the next cycle.
    `PCSH_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

bind pot_channel_selector_hysteresis_unit pcsh_checker u_pcsh_checker (.*);
